// File: rtl/rlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlr_pkg: shared types and constants for the running linear regression
// Holds the word formats, the sequencer states and the requests that the
// sequencer sends to the serial multiplier and the serial divider.
// ---------------------------------------------------------------------------
package rlr_pkg;

  // Largest number of points that are accumulated.
  localparam logic [15:0] MAX_POINTS = 16'd65535;

  // Widths of the working values.
  localparam int MulAW  = 48;  // multiplicand
  localparam int MulBW  = 32;  // multiplier, walked one bit per cycle
  localparam int ProdW  = 66;  // signed product and difference width
  localparam int DivDW  = 64;  // divisor and dividend magnitude
  localparam int QuotW  = 32;  // quotient bits developed one per cycle

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [15:0]        point_count;
    logic               degenerate;
    logic               full_res;
  } out_t;

  typedef struct packed {
    logic                    start;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
    logic                    half;   // only the low 16 bits of b matter
  } mul_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [ProdW-1:0] numer;
    logic [DivDW-1:0]        denom;
    logic                    frac16; // quotient carries 16 fraction bits
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MXX,
    ST_MXY,
    ST_MNXY,
    ST_MSXY,
    ST_MNXX,
    ST_MSXX,
    ST_DIVS,
    ST_MSSX,
    ST_DIVI,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/rlr_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlr_mul: bit-serial signed multiplier
// Sign-magnitude shift-and-add, multiplier bits taken MSB first, one per
// cycle: 16 bits for a short multiplier, all 32 for a full one.
// ---------------------------------------------------------------------------
module rlr_mul (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rlr_pkg::mul_req_t              req,
  output logic signed [rlr_pkg::ProdW-1:0]    prod,
  output logic                                done
);

  logic [rlr_pkg::MulAW-1:0] amag;
  logic [rlr_pkg::MulBW-1:0] bmag;
  logic [rlr_pkg::ProdW-1:0] acc_r;
  logic [rlr_pkg::MulAW-1:0] am_r;
  logic [rlr_pkg::MulBW-1:0] bm_r;
  logic [5:0]                cnt_r;
  logic                      neg_r;
  logic                      busy_r;
  logic                      done_r;

  // Operand magnitudes.
  always_comb begin
    amag = req.a[rlr_pkg::MulAW-1] ? (~req.a + 1'b1) : req.a;
    bmag = req.b[rlr_pkg::MulBW-1] ? (~req.b + 1'b1) : req.b;
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.half ? 6'd16 : 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      am_r  <= amag;
      bm_r  <= req.half ? {bmag[15:0], 16'd0} : bmag;
      neg_r <= req.a[rlr_pkg::MulAW-1] ^ req.b[rlr_pkg::MulBW-1];
    end else if (busy_r) begin
      acc_r <= {acc_r[rlr_pkg::ProdW-2:0], 1'b0}
             + (bm_r[rlr_pkg::MulBW-1] ? {18'd0, am_r} : '0);
      bm_r  <= {bm_r[rlr_pkg::MulBW-2:0], 1'b0};
    end
  end

  assign prod = neg_r ? $signed(~acc_r + 1'b1) : $signed(acc_r);
  assign done = done_r;

endmodule
`default_nettype wire

// File: rtl/rlr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlr_div: bit-serial saturating divider
// Restoring division, one quotient bit per cycle for a 32-bit quotient. Truncates
// toward zero and saturates the signed 32-bit code; overflow is seen up front.
// ---------------------------------------------------------------------------
module rlr_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire rlr_pkg::div_req_t       req,
  output logic signed [31:0]           quot,
  output logic                         done
);

  logic [rlr_pkg::DivDW-1:0]  mag;
  logic [79:0]                dvd;
  logic                       sat;
  logic [rlr_pkg::DivDW:0]    trial;
  logic                       fits;
  logic [rlr_pkg::QuotW-1:0]  limit;
  logic [rlr_pkg::QuotW-1:0]  qclip;
  logic [rlr_pkg::DivDW-1:0]  rem_r;
  logic [31:0]                lo_r;
  logic [rlr_pkg::DivDW-1:0]  den_r;
  logic [rlr_pkg::QuotW-1:0]  q_r;
  logic                       neg_r;
  logic                       sat_r;
  logic [5:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;

  // Dividend alignment and the overflow test.
  always_comb begin
    mag   = req.numer[rlr_pkg::ProdW-1] ? 64'(~req.numer + 1'b1) : 64'(req.numer);
    dvd   = req.frac16 ? {mag, 16'd0} : {16'd0, mag};
    sat   = {16'd0, dvd[79:32]} >= req.denom;
    trial = {rem_r, lo_r[31]};
    fits  = trial >= {1'b0, den_r};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= sat ? 6'd1 : 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {16'd0, dvd[79:32]};
      lo_r  <= dvd[31:0];
      den_r <= req.denom;
      q_r   <= '0;
      neg_r <= req.numer[rlr_pkg::ProdW-1];
      sat_r <= sat;
    end else if (busy_r && !sat_r) begin
      rem_r <= fits ? 64'(trial - {1'b0, den_r}) : trial[63:0];
      lo_r  <= {lo_r[30:0], 1'b0};
      q_r   <= {q_r[30:0], fits};
    end
  end

  // Clamp, then apply the sign.
  always_comb begin
    limit = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    qclip = (sat_r || (q_r > limit)) ? limit : q_r;
  end

  assign quot = neg_r ? $signed(~qclip + 1'b1) : $signed(qclip);
  assign done = done_r;

endmodule
`default_nettype wire

// File: rtl/running_linear_regression.sv
`timescale 1ns / 1ps
`default_nettype none
// Each accepted word runs through four short multiplies, three full multiplies, two
// divisions and one output step before its result word. A degenerate fit, a saturated
// slope or a dropped point finishes sooner.
// The single shared bit-serial multiplier and divider take one word at a time; the input
// stalls until the sequencer is back in idle. The output register lets the next
// word enter while a result still waits. Synchronous active-low reset clears
// all running sums, the point count and the handshake state.
// ---------------------------------------------------------------------------
// running_linear_regression: online least-squares line fit
// Keeps running sums of x, y, x*x and x*y, then works out the slope in Q16.16
// and the intercept in Q24.8 with a serial multiplier and a serial divider.
// ---------------------------------------------------------------------------
module running_linear_regression (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rlr_pkg::in_t  in_word,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rlr_pkg::out_t      out_word
);

  rlr_pkg::state_t state_r, state_nxt;
  logic            launched_r, launched_nxt;

  logic signed [15:0] x_r;
  logic signed [15:0] y_r;
  logic signed [31:0] sx_r;
  logic signed [31:0] sy_r;
  logic [45:0]        sxx_r;
  logic signed [46:0] sxy_r;
  logic [15:0]        cnt_r;
  logic signed [rlr_pkg::ProdW-1:0] t1_r;
  logic signed [rlr_pkg::ProdW-1:0] numer_r;
  logic signed [rlr_pkg::ProdW-1:0] den_r;
  logic signed [31:0] slope_r;
  logic               degen_r;
  logic               full_r;
  rlr_pkg::out_t      res_r;
  rlr_pkg::out_t      out_r;
  logic               out_valid_r;

  rlr_pkg::mul_req_t  mreq;
  rlr_pkg::div_req_t  dreq;
  logic signed [rlr_pkg::ProdW-1:0] prod;
  logic               mul_done;
  logic signed [31:0] quot;
  logic               div_done;
  logic               in_acc;
  logic               den_pos;
  logic               out_free;

  rlr_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .prod(prod), .done(mul_done));
  rlr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .quot(quot), .done(div_done));

  assign in_stall = (state_r != rlr_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign den_pos  = !den_r[rlr_pkg::ProdW-1] && (den_r != '0);
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: next state and unit requests.
  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    mreq         = '0;
    dreq         = '0;
    case (state_r)
      rlr_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (cnt_r >= rlr_pkg::MAX_POINTS) ? rlr_pkg::ST_MNXY : rlr_pkg::ST_MXX;
        end
      end
      rlr_pkg::ST_MXX, rlr_pkg::ST_MXY, rlr_pkg::ST_MNXY, rlr_pkg::ST_MSXY,
      rlr_pkg::ST_MNXX, rlr_pkg::ST_MSXX, rlr_pkg::ST_MSSX: begin
        mreq.start = !launched_r;
        case (state_r)
          rlr_pkg::ST_MXX: begin
            mreq.a = 48'(x_r); mreq.b = 32'(x_r); mreq.half = 1'b1;
          end
          rlr_pkg::ST_MXY: begin
            mreq.a = 48'(x_r); mreq.b = 32'(y_r); mreq.half = 1'b1;
          end
          rlr_pkg::ST_MNXY: begin
            mreq.a = 48'(sxy_r); mreq.b = $signed({16'd0, cnt_r}); mreq.half = 1'b1;
          end
          rlr_pkg::ST_MSXY: begin
            mreq.a = 48'(sx_r); mreq.b = sy_r;
          end
          rlr_pkg::ST_MNXX: begin
            mreq.a = $signed({2'b00, sxx_r}); mreq.b = $signed({16'd0, cnt_r});
            mreq.half = 1'b1;
          end
          rlr_pkg::ST_MSXX: begin
            mreq.a = 48'(sx_r); mreq.b = sx_r;
          end
          default: begin
            mreq.a = 48'(sx_r); mreq.b = slope_r;
          end
        endcase
        if (!launched_r) begin
          launched_nxt = 1'b1;
        end else if (mul_done) begin
          launched_nxt = 1'b0;
          case (state_r)
            rlr_pkg::ST_MXX:  state_nxt = rlr_pkg::ST_MXY;
            rlr_pkg::ST_MXY:  state_nxt = rlr_pkg::ST_MNXY;
            rlr_pkg::ST_MNXY: state_nxt = rlr_pkg::ST_MSXY;
            rlr_pkg::ST_MSXY: state_nxt = rlr_pkg::ST_MNXX;
            rlr_pkg::ST_MNXX: state_nxt = rlr_pkg::ST_MSXX;
            rlr_pkg::ST_MSXX: state_nxt = rlr_pkg::ST_DIVS;
            default:          state_nxt = rlr_pkg::ST_DIVI;
          endcase
        end
      end
      rlr_pkg::ST_DIVS: begin
        if (!den_pos) begin
          state_nxt = rlr_pkg::ST_MSSX;
        end else begin
          dreq.start  = !launched_r;
          dreq.numer  = numer_r;
          dreq.denom  = den_r[63:0];
          dreq.frac16 = 1'b1;
          if (!launched_r) begin
            launched_nxt = 1'b1;
          end else if (div_done) begin
            launched_nxt = 1'b0;
            state_nxt    = rlr_pkg::ST_MSSX;
          end
        end
      end
      rlr_pkg::ST_DIVI: begin
        dreq.start = !launched_r;
        dreq.numer = t1_r;
        dreq.denom = {40'd0, cnt_r, 8'd0};
        if (!launched_r) begin
          launched_nxt = 1'b1;
        end else if (div_done) begin
          launched_nxt = 1'b0;
          state_nxt    = rlr_pkg::ST_DONE;
        end
      end
      rlr_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = rlr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rlr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlr_pkg::ST_IDLE;
      launched_r  <= 1'b0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      sxy_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
      // Running sums are updated once the products are known.
      if (state_r == rlr_pkg::ST_MXX && launched_r && mul_done) begin
        sxx_r <= sxx_r + prod[45:0];
      end
      if (state_r == rlr_pkg::ST_MXY && launched_r && mul_done) begin
        sxy_r <= sxy_r + prod[46:0];
        sx_r  <= sx_r + 32'(x_r);
        sy_r  <= sy_r + 32'(y_r);
        cnt_r <= cnt_r + 16'd1;
      end
      // Output register.
      if (state_r == rlr_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working values.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r     <= in_word.x_value;
      y_r     <= in_word.y_value;
      full_r  <= (cnt_r >= rlr_pkg::MAX_POINTS);
      slope_r <= '0;
      degen_r <= 1'b0;
    end
    if (launched_r && mul_done) begin
      case (state_r)
        rlr_pkg::ST_MNXY, rlr_pkg::ST_MNXX: t1_r <= prod;
        rlr_pkg::ST_MSXY: numer_r <= t1_r - prod;
        rlr_pkg::ST_MSXX: den_r <= t1_r - prod;
        rlr_pkg::ST_MSSX: t1_r <= $signed({{18{sy_r[31]}}, sy_r, 16'd0}) - prod;
        default: ;
      endcase
    end
    if (state_r == rlr_pkg::ST_DIVS && !den_pos) begin
      degen_r <= 1'b1;
    end
    if (state_r == rlr_pkg::ST_DIVS && launched_r && div_done) begin
      slope_r <= quot;
    end
    if (state_r == rlr_pkg::ST_DIVI && launched_r && div_done) begin
      res_r.slope       <= slope_r;
      res_r.intercept   <= quot;
      res_r.point_count <= cnt_r;
      res_r.degenerate  <= degen_r;
      res_r.full_res    <= full_r;
    end
    if (state_r == rlr_pkg::ST_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

// File: rtl/rlr_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlr_chk: port-level checks for the running linear regression
// Watches the handshakes and the result word flags over time.
// ---------------------------------------------------------------------------
module rlr_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire rlr_pkg::out_t out_word
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // One word at a time: an accepted word blocks the input next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // A degenerate fit reports a zero slope.
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.degenerate |-> out_word.slope == 32'sd0)
    else $error("degenerate fit with nonzero slope");

  // A dropped point only happens at the count limit.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.full_res |-> out_word.point_count == rlr_pkg::MAX_POINTS)
    else $error("point dropped below the limit");

  // Every result covers at least one point.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.point_count != 16'd0)
    else $error("result with no points");

endmodule

bind running_linear_regression rlr_chk u_rlr_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
`default_nettype wire
